[sv/svx_pkg.sv]
package svx_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int TAPE_DEPTH = 256;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int TA_W = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
	localparam int OPS_VALID = 16;
	localparam int CFG_W = 10;
	localparam logic [7:0] OUT_LIMIT_RESET = 8'd24;
	localparam logic [9:0] STEP_LIMIT_RESET = 10'd384;

	typedef enum logic [0:0] {
		CFG_OUTPUT_LIMIT = 1'b0,
		CFG_STEP_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OPC_HALT = 4'h0,
		OPC_PUSH = 4'h1,
		OPC_DROP = 4'h2,
		OPC_DUP = 4'h3,
		OPC_SWAP = 4'h4,
		OPC_ADD = 4'h5,
		OPC_SUB = 4'h6,
		OPC_XOR = 4'h7,
		OPC_LOAD = 4'h8,
		OPC_STORE = 4'h9,
		OPC_PRINT = 4'ha,
		OPC_INPUT = 4'hb,
		OPC_HOME = 4'hc,
		OPC_NOP = 4'hd,
		OPC_RSVD = 4'he,
		OPC_TRIGGER = 4'hf
	} opcode_t;

	typedef enum logic [3:0] {
		CAUSE_RUN = 4'd0,
		CAUSE_HALT = 4'd1,
		CAUSE_STACK = 4'd2,
		CAUSE_TAPE = 4'd3,
		CAUSE_BAD_INSN = 4'd4,
		CAUSE_OUT_LIMIT = 4'd5,
		CAUSE_NO_INPUT = 4'd6,
		CAUSE_TRIGGER = 4'd7,
		CAUSE_BUDGET = 4'd8
	} cause_t;

	typedef enum logic [3:0] {
		VOP_NONE = 4'd0,
		VOP_PUSH_IMM = 4'd1,
		VOP_PUSH_IN = 4'd2,
		VOP_PUSH_TAPE = 4'd3,
		VOP_DUP = 4'd4,
		VOP_POP = 4'd5,
		VOP_SWAP = 4'd6,
		VOP_ADD = 4'd7,
		VOP_SUB = 4'd8,
		VOP_XOR = 4'd9
	} value_op_t;

	typedef struct packed {
		logic [7:0] kind;
		logic [7:0] flag_bits;
		logic [31:0] spare_bits;
		logic signed [15:0] tape_offset;
		logic [63:0] immediate;
		logic [63:0] input_word;
		logic input_present;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic print_valid;
		logic [63:0] print_value;
		logic halted;
		logic [3:0] cause;
		logic [6:0] stack_depth;
		logic done_res;
	} out_item_t;

	typedef struct packed {
		logic halt;
		cause_t cause;
		logic [SP_W-1:0] sp;
		logic [7:0] print_count;
		logic [9:0] step_count;
	} vm_state_t;

	typedef struct packed {
		value_op_t op;
		logic stk_we;
		logic [SA_W-1:0] stk_waddr;
		logic [SA_W-1:0] stk_raddr;
		logic tape_we;
		logic [TA_W-1:0] tape_addr;
		logic printed;
		logic halted;
		cause_t cause;
		logic [SP_W-1:0] depth;
		logic done;
	} exec_ctrl_t;

endpackage

[sv/svx_decode.sv]
module svx_decode (
	input svx_pkg::in_item_t item,
	input svx_pkg::vm_state_t st,
	input logic [7:0] output_limit,
	input logic [9:0] step_limit,
	output svx_pkg::vm_state_t nx,
	output svx_pkg::exec_ctrl_t ctl
);

	logic [15:0] off_u;
	logic tape_bad;
	logic insn_bad;
	logic stk_empty;
	logic stk_full;
	logic [svx_pkg::SP_W-1:0] sp_inc;
	logic [svx_pkg::SP_W-1:0] sp_dec;
	logic [svx_pkg::SP_W-1:0] sp_dec2;
	logic [9:0] sc_inc;
	svx_pkg::opcode_t opc;

	assign off_u = item.tape_offset;
	assign tape_bad = off_u[15] || (off_u >= 16'(svx_pkg::TAPE_DEPTH));
	assign insn_bad = (item.kind >= 8'(svx_pkg::OPS_VALID)) || (item.flag_bits != 8'd0)
		|| (item.spare_bits != 32'd0);
	assign stk_empty = (st.sp == '0);
	assign stk_full = (st.sp >= svx_pkg::SP_W'(svx_pkg::STACK_DEPTH));
	assign sp_inc = st.sp + svx_pkg::SP_W'(1);
	assign sp_dec = st.sp - svx_pkg::SP_W'(1);
	assign sp_dec2 = st.sp - svx_pkg::SP_W'(2);
	assign sc_inc = st.step_count + 10'd1;
	assign opc = svx_pkg::opcode_t'(item.kind[3:0]);

	always_comb begin
		nx = st;
		ctl.op = svx_pkg::VOP_NONE;
		ctl.stk_we = 1'b0;
		ctl.stk_waddr = sp_dec[svx_pkg::SA_W-1:0];
		ctl.stk_raddr = sp_dec2[svx_pkg::SA_W-1:0];
		ctl.tape_we = 1'b0;
		ctl.tape_addr = off_u[svx_pkg::TA_W-1:0];
		ctl.printed = 1'b0;
		if (!st.halt) begin
			if (st.step_count >= step_limit) begin
				nx.halt = 1'b1;
				nx.cause = svx_pkg::CAUSE_BUDGET;
			end else if (insn_bad) begin
				nx.halt = 1'b1;
				nx.cause = svx_pkg::CAUSE_BAD_INSN;
			end else begin
				case (opc)
					svx_pkg::OPC_HALT: begin
						nx.halt = 1'b1;
						nx.cause = svx_pkg::CAUSE_HALT;
					end
					svx_pkg::OPC_PUSH, svx_pkg::OPC_INPUT, svx_pkg::OPC_LOAD: begin
						if (opc == svx_pkg::OPC_LOAD && tape_bad) begin
							nx.halt = 1'b1;
							nx.cause = svx_pkg::CAUSE_TAPE;
						end else if (opc == svx_pkg::OPC_INPUT && !item.input_present) begin
							nx.halt = 1'b1;
							nx.cause = svx_pkg::CAUSE_NO_INPUT;
						end else if (stk_full) begin
							nx.halt = 1'b1;
							nx.cause = svx_pkg::CAUSE_STACK;
						end else begin
							nx.sp = sp_inc;
							ctl.stk_we = !stk_empty;
							if (opc == svx_pkg::OPC_PUSH) begin
								ctl.op = svx_pkg::VOP_PUSH_IMM;
							end else if (opc == svx_pkg::OPC_INPUT) begin
								ctl.op = svx_pkg::VOP_PUSH_IN;
							end else begin
								ctl.op = svx_pkg::VOP_PUSH_TAPE;
							end
						end
					end
					svx_pkg::OPC_DROP: begin
						if (stk_empty) begin
							nx.halt = 1'b1;
							nx.cause = svx_pkg::CAUSE_STACK;
						end else begin
							nx.sp = sp_dec;
							ctl.op = svx_pkg::VOP_POP;
						end
					end
					svx_pkg::OPC_DUP: begin
						if (stk_empty || stk_full) begin
							nx.halt = 1'b1;
							nx.cause = svx_pkg::CAUSE_STACK;
						end else begin
							nx.sp = sp_inc;
							ctl.op = svx_pkg::VOP_DUP;
							ctl.stk_we = 1'b1;
						end
					end
					svx_pkg::OPC_SWAP: begin
						if (st.sp < svx_pkg::SP_W'(2)) begin
							nx.halt = 1'b1;
							nx.cause = svx_pkg::CAUSE_STACK;
						end else begin
							ctl.op = svx_pkg::VOP_SWAP;
							ctl.stk_we = 1'b1;
							ctl.stk_waddr = sp_dec2[svx_pkg::SA_W-1:0];
						end
					end
					svx_pkg::OPC_ADD, svx_pkg::OPC_SUB, svx_pkg::OPC_XOR: begin
						if (st.sp < svx_pkg::SP_W'(2)) begin
							nx.halt = 1'b1;
							nx.cause = svx_pkg::CAUSE_STACK;
							nx.sp = '0;
						end else begin
							nx.sp = sp_dec;
							if (opc == svx_pkg::OPC_ADD) begin
								ctl.op = svx_pkg::VOP_ADD;
							end else if (opc == svx_pkg::OPC_SUB) begin
								ctl.op = svx_pkg::VOP_SUB;
							end else begin
								ctl.op = svx_pkg::VOP_XOR;
							end
						end
					end
					svx_pkg::OPC_STORE: begin
						if (tape_bad) begin
							nx.halt = 1'b1;
							nx.cause = svx_pkg::CAUSE_TAPE;
						end else if (stk_empty) begin
							nx.halt = 1'b1;
							nx.cause = svx_pkg::CAUSE_STACK;
						end else begin
							nx.sp = sp_dec;
							ctl.op = svx_pkg::VOP_POP;
							ctl.tape_we = 1'b1;
						end
					end
					svx_pkg::OPC_PRINT: begin
						if (st.print_count >= output_limit) begin
							nx.halt = 1'b1;
							nx.cause = svx_pkg::CAUSE_OUT_LIMIT;
						end else if (stk_empty) begin
							nx.halt = 1'b1;
							nx.cause = svx_pkg::CAUSE_STACK;
						end else begin
							nx.sp = sp_dec;
							nx.print_count = st.print_count + 8'd1;
							ctl.op = svx_pkg::VOP_POP;
							ctl.printed = 1'b1;
						end
					end
					svx_pkg::OPC_HOME, svx_pkg::OPC_NOP: begin
					end
					svx_pkg::OPC_RSVD: begin
						nx.halt = 1'b1;
						nx.cause = svx_pkg::CAUSE_BAD_INSN;
					end
					svx_pkg::OPC_TRIGGER: begin
						nx.halt = 1'b1;
						nx.cause = svx_pkg::CAUSE_TRIGGER;
					end
					default: begin
					end
				endcase
				nx.step_count = sc_inc;
				if (sc_inc >= step_limit) begin
					nx.halt = 1'b1;
					nx.cause = svx_pkg::CAUSE_BUDGET;
				end
			end
		end
		ctl.halted = nx.halt;
		ctl.cause = nx.cause;
		ctl.depth = nx.sp;
		ctl.done = nx.halt || item.last;
	end

endmodule

[sv/stack_vm_executor_unit.sv]
// Stack-machine executor. Each item on the input channel carries one instruction, and
// each accepted item yields exactly one result item on the output channel, in order.
// Both channels use valid and stall; an item moves at a clock edge with valid high and
// stall low. The user must write the configuration registers (output limit, step limit)
// through cfg_we, cfg_index and cfg_data only while idle; the block does not enforce it.
// The whole control outcome of an instruction (halt, cause, stack depth, counters) is
// settled in the cycle the item is accepted, while the stack and tape memories are read.
// In the execute stage the read data, with forwarding from the previous write, produces the
// new top of stack, the memory write and the result, which lands in the output register.
// While the receiver does not stall, items are accepted one per cycle with no bubbles,
// so throughput is one item per clock.
// When the receiver stalls, the output register holds its item and the execute stage
// holds one more; the input then stalls until the output register is taken.
// Reset empties the pipeline, clears the stack pointer, the counters, the halt status,
// and every tape word (through per-word valid bits), and restores the limits to 24 and
// 384. The block can accept items as soon as reset is released.
module stack_vm_executor_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input svx_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output svx_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [svx_pkg::CFG_W-1:0] cfg_data
);

	logic [63:0] stack_mem [svx_pkg::STACK_DEPTH];
	logic [63:0] tape_mem [svx_pkg::TAPE_DEPTH];
	logic [svx_pkg::TAPE_DEPTH-1:0] tape_vld_q;

	svx_pkg::vm_state_t st_q;
	svx_pkg::vm_state_t st_n;
	svx_pkg::exec_ctrl_t ctl_n;
	logic [7:0] olim_q;
	logic [9:0] slim_q;

	logic accept;
	logic go;
	logic valid_s1;
	svx_pkg::exec_ctrl_t ctl_s1;
	logic [63:0] imm_s1;
	logic [63:0] word_s1;
	logic [63:0] stk_rd_s1;
	logic [63:0] tape_rd_s1;
	logic tvld_s1;

	logic lw_stk_en_q;
	logic [svx_pkg::SA_W-1:0] lw_stk_addr_q;
	logic [63:0] lw_stk_data_q;
	logic lw_tape_en_q;
	logic [svx_pkg::TA_W-1:0] lw_tape_addr_q;
	logic [63:0] lw_tape_data_q;

	logic [63:0] top_q;
	logic [63:0] top_n;
	logic [63:0] stk_val;
	logic [63:0] tape_val;

	logic out_valid_q;
	svx_pkg::out_item_t out_item_q;

	assign go = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go;
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	svx_decode u_decode (
		.item(in_item),
		.st(st_q),
		.output_limit(olim_q),
		.step_limit(slim_q),
		.nx(st_n),
		.ctl(ctl_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{halt: 1'b0, cause: svx_pkg::CAUSE_RUN, sp: '0,
				print_count: 8'd0, step_count: 10'd0};
			olim_q <= svx_pkg::OUT_LIMIT_RESET;
			slim_q <= svx_pkg::STEP_LIMIT_RESET;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			lw_stk_en_q <= 1'b0;
			lw_tape_en_q <= 1'b0;
			tape_vld_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == svx_pkg::CFG_OUTPUT_LIMIT) begin
					olim_q <= cfg_data[7:0];
				end else begin
					slim_q <= cfg_data[9:0];
				end
			end
			if (accept) begin
				st_q <= st_n;
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
			if (go) begin
				out_valid_q <= 1'b1;
				lw_stk_en_q <= ctl_s1.stk_we;
				lw_tape_en_q <= ctl_s1.tape_we;
				if (ctl_s1.tape_we) begin
					tape_vld_q[ctl_s1.tape_addr] <= 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stk_rd_s1 <= stack_mem[ctl_n.stk_raddr];
		end
		if (go && ctl_s1.stk_we) begin
			stack_mem[ctl_s1.stk_waddr] <= top_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tape_rd_s1 <= tape_mem[ctl_n.tape_addr];
		end
		if (go && ctl_s1.tape_we) begin
			tape_mem[ctl_s1.tape_addr] <= top_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_n;
			imm_s1 <= in_item.immediate;
			word_s1 <= in_item.input_word;
			tvld_s1 <= tape_vld_q[ctl_n.tape_addr];
		end
		if (go) begin
			top_q <= top_n;
			lw_stk_addr_q <= ctl_s1.stk_waddr;
			lw_stk_data_q <= top_q;
			lw_tape_addr_q <= ctl_s1.tape_addr;
			lw_tape_data_q <= top_q;
			out_item_q.print_valid <= ctl_s1.printed;
			out_item_q.print_value <= ctl_s1.printed ? top_q : 64'd0;
			out_item_q.halted <= ctl_s1.halted;
			out_item_q.cause <= ctl_s1.cause;
			out_item_q.stack_depth <= 7'(ctl_s1.depth);
			out_item_q.done_res <= ctl_s1.done;
		end
	end

	// The memory read was issued no earlier than the previous item's write, possibly in the
	// same cycle, so a matching address takes the data of that write.
	always_comb begin
		if (lw_stk_en_q && (lw_stk_addr_q == ctl_s1.stk_raddr)) begin
			stk_val = lw_stk_data_q;
		end else begin
			stk_val = stk_rd_s1;
		end
		if (lw_tape_en_q && (lw_tape_addr_q == ctl_s1.tape_addr)) begin
			tape_val = lw_tape_data_q;
		end else if (tvld_s1) begin
			tape_val = tape_rd_s1;
		end else begin
			tape_val = 64'd0;
		end
	end

	always_comb begin
		case (ctl_s1.op)
			svx_pkg::VOP_PUSH_IMM: top_n = imm_s1;
			svx_pkg::VOP_PUSH_IN: top_n = word_s1;
			svx_pkg::VOP_PUSH_TAPE: top_n = tape_val;
			svx_pkg::VOP_POP: top_n = stk_val;
			svx_pkg::VOP_SWAP: top_n = stk_val;
			svx_pkg::VOP_ADD: top_n = stk_val + top_q;
			svx_pkg::VOP_SUB: top_n = stk_val - top_q;
			svx_pkg::VOP_XOR: top_n = stk_val ^ top_q;
			default: top_n = top_q;
		endcase
	end

endmodule

[verif/stack_vm_executor_unit_tb.sv]
`timescale 1ns / 1ps

module stack_vm_executor_unit_tb;
	import svx_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	stack_vm_executor_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Machine state as the block should hold it.
	logic [63:0] vm_stack [0:STACK_DEPTH-1];
	logic [63:0] vm_tape [0:TAPE_DEPTH-1];
	int vm_sp;
	logic vm_halt;
	cause_t vm_cause;
	logic [7:0] vm_prints;
	logic [9:0] vm_steps;
	logic [7:0] lim_out;
	logic [9:0] lim_step;

	out_item_t status_q [$];
	in_item_t dir_items [$];
	bit dir_typed [$];
	out_item_t dir_res [$];

	int err_count = 0;
	int n_items = 0;
	int noise_n = 0;
	int gap_pct = 20;
	int stall_pct = 20;
	int stall_left = 0;
	bit quiet = 1'b0;
	bit vld_sh = 1'b0;

	function automatic void stop(input cause_t why);
		vm_halt = 1'b1;
		vm_cause = why;
	endfunction

	function automatic void push_word(input logic [63:0] v);
		if (vm_sp >= STACK_DEPTH) begin
			stop(CAUSE_STACK);
		end else begin
			vm_stack[vm_sp] = v;
			vm_sp = vm_sp + 1;
		end
	endfunction

	function automatic logic [63:0] pop_word();
		if (vm_sp == 0) begin
			stop(CAUSE_STACK);
			return 64'd0;
		end
		vm_sp = vm_sp - 1;
		return vm_stack[vm_sp];
	endfunction

	function automatic bit tape_ok(input logic [15:0] raw);
		if (raw[15] || raw >= 16'(TAPE_DEPTH)) begin
			stop(CAUSE_TAPE);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void vm_reset();
		for (int i = 0; i < STACK_DEPTH; i++) vm_stack[i] = '0;
		for (int i = 0; i < TAPE_DEPTH; i++) vm_tape[i] = '0;
		vm_sp = 0;
		vm_halt = 1'b0;
		vm_cause = CAUSE_RUN;
		vm_prints = '0;
		vm_steps = '0;
		lim_out = OUT_LIMIT_RESET;
		lim_step = STEP_LIMIT_RESET;
	endfunction

	function automatic out_item_t exec_insn(input in_item_t it);
		out_item_t r;
		logic [63:0] a;
		logic [63:0] b;
		logic [15:0] raw;
		logic printed;
		logic [63:0] pval;
		printed = 1'b0;
		pval = '0;
		raw = it.tape_offset;
		if (!vm_halt) begin
			if (vm_steps >= lim_step) begin
				stop(CAUSE_BUDGET);
			end else if (it.kind >= OPS_VALID || it.flag_bits != 0 || it.spare_bits != 0) begin
				stop(CAUSE_BAD_INSN);
			end else begin
				case (it.kind[3:0])
					OPC_HALT: stop(CAUSE_HALT);
					OPC_PUSH: push_word(it.immediate);
					OPC_DROP: a = pop_word();
					OPC_DUP: begin
						if (vm_sp == 0 || vm_sp >= STACK_DEPTH) stop(CAUSE_STACK);
						else push_word(vm_stack[vm_sp-1]);
					end
					OPC_SWAP: begin
						if (vm_sp < 2) begin
							stop(CAUSE_STACK);
						end else begin
							a = vm_stack[vm_sp-1];
							vm_stack[vm_sp-1] = vm_stack[vm_sp-2];
							vm_stack[vm_sp-2] = a;
						end
					end
					OPC_ADD, OPC_SUB, OPC_XOR: begin
						b = pop_word();
						if (!vm_halt) a = pop_word();
						if (!vm_halt) begin
							if (it.kind[3:0] == OPC_ADD) a = a + b;
							else if (it.kind[3:0] == OPC_SUB) a = a - b;
							else a = a ^ b;
							push_word(a);
						end
					end
					OPC_LOAD: begin
						if (tape_ok(raw)) push_word(vm_tape[raw]);
					end
					OPC_STORE: begin
						if (tape_ok(raw)) begin
							a = pop_word();
							if (!vm_halt) vm_tape[raw] = a;
						end
					end
					OPC_PRINT: begin
						if (vm_prints >= lim_out) begin
							stop(CAUSE_OUT_LIMIT);
						end else begin
							a = pop_word();
							if (!vm_halt) begin
								vm_prints = vm_prints + 8'd1;
								printed = 1'b1;
								pval = a;
							end
						end
					end
					OPC_INPUT: begin
						if (!it.input_present) stop(CAUSE_NO_INPUT);
						else push_word(it.input_word);
					end
					OPC_HOME, OPC_NOP: ;
					OPC_RSVD: stop(CAUSE_BAD_INSN);
					default: stop(CAUSE_TRIGGER);
				endcase
				vm_steps = vm_steps + 10'd1;
				if (vm_steps >= lim_step) stop(CAUSE_BUDGET);
			end
		end
		r.print_valid = printed;
		r.print_value = pval;
		r.halted = vm_halt;
		r.cause = vm_cause;
		r.stack_depth = 7'(vm_sp);
		r.done_res = vm_halt || it.last;
		return r;
	endfunction

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic in_item_t basic_insn(input opcode_t op);
		in_item_t it;
		it.kind = {4'h0, op};
		it.flag_bits = '0;
		it.spare_bits = '0;
		it.tape_offset = 16'($urandom);
		it.immediate = rand_word();
		it.input_word = rand_word();
		it.input_present = 1'($urandom_range(0, 1));
		it.last = ($urandom_range(0, 15) == 0);
		return it;
	endfunction

	function automatic in_item_t mk(input opcode_t op, input logic [63:0] imm,
			input logic [15:0] off, input logic [63:0] word, input bit present, input bit last);
		in_item_t it;
		it = basic_insn(op);
		it.immediate = imm;
		it.tape_offset = off;
		it.input_word = word;
		it.input_present = present;
		it.last = last;
		return it;
	endfunction

	function automatic out_item_t res_of(input bit pv, input logic [63:0] val, input bit h,
			input cause_t c, input int depth, input bit done);
		out_item_t r;
		r.print_valid = pv;
		r.print_value = val;
		r.halted = h;
		r.cause = c;
		r.stack_depth = 7'(depth);
		r.done_res = done;
		return r;
	endfunction

	function automatic logic [15:0] tape_pick();
		if ($urandom_range(0, 1)) return 16'($urandom_range(0, TAPE_DEPTH - 1));
		return 16'($urandom_range(0, 7));
	endfunction

	// Well-formed instruction that keeps the machine running.
	function automatic in_item_t gen_clean_insn(input int fill_pct);
		opcode_t op;
		bit ok;
		in_item_t it;
		ok = 1'b0;
		op = OPC_NOP;
		while (!ok) begin
			if ($urandom_range(0, 99) < fill_pct) begin
				case ($urandom_range(0, 3))
					0: op = OPC_PUSH;
					1: op = OPC_INPUT;
					2: op = OPC_LOAD;
					default: op = OPC_DUP;
				endcase
			end else begin
				op = opcode_t'($urandom_range(1, 13));
			end
			case (op)
				OPC_PUSH, OPC_INPUT, OPC_LOAD: ok = vm_sp < STACK_DEPTH;
				OPC_DUP: ok = vm_sp > 0 && vm_sp < STACK_DEPTH;
				OPC_DROP, OPC_STORE: ok = vm_sp > 0;
				OPC_SWAP, OPC_ADD, OPC_SUB, OPC_XOR: ok = vm_sp > 1;
				OPC_PRINT: ok = vm_sp > 0 && vm_prints < lim_out;
				default: ok = 1'b1;
			endcase
		end
		it = basic_insn(op);
		if (op == OPC_INPUT) it.input_present = 1'b1;
		if (op == OPC_LOAD || op == OPC_STORE) it.tape_offset = tape_pick();
		return it;
	endfunction

	function automatic in_item_t noise_insn();
		in_item_t it;
		it.kind = 8'($urandom);
		it.flag_bits = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		it.spare_bits = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
		it.tape_offset = 16'($urandom);
		it.immediate = {$urandom, $urandom};
		it.input_word = {$urandom, $urandom};
		it.input_present = 1'($urandom_range(0, 1));
		it.last = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic int idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 12;
			default: return 40;
		endcase
	endfunction

	task automatic set_valid(input bit v);
		if (vld_sh != v) begin
			in_valid <= v;
			vld_sh = v;
		end
	endtask

	task automatic send_insn(input in_item_t it, input bit typed, input out_item_t typed_res);
		out_item_t res;
		set_valid(1'b1);
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		res = exec_insn(it);
		status_q.push_back(typed ? typed_res : res);
		n_items++;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			set_valid(1'b0);
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic run_insn(input in_item_t it);
		send_insn(it, 1'b0, '0);
	endtask

	task automatic wait_idle();
		set_valid(1'b0);
		while (status_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limits(input logic [7:0] out_lim, input logic [9:0] step_lim);
		cfg_we <= 1'b1;
		cfg_index <= CFG_OUTPUT_LIMIT;
		cfg_data <= {2'b00, out_lim};
		@(posedge clk);
		lim_out = out_lim;
		cfg_index <= CFG_STEP_LIMIT;
		cfg_data <= step_lim;
		@(posedge clk);
		lim_step = step_lim;
		cfg_we <= 1'b0;
	endtask

	task automatic run_clean(input int count, input int fill_pct);
		int n;
		n = 0;
		while (n < count && int'(vm_steps) + 2 < int'(lim_step)) begin
			if ($urandom_range(0, 49) == 0) begin
				gap_pct = idle_pct();
				stall_pct = idle_pct();
			end
			run_insn(gen_clean_insn(fill_pct));
			n++;
		end
	endtask

	// Bring the program to an end through one randomly chosen halting cause.
	task automatic finish_program();
		in_item_t it;
		opcode_t op;
		case ($urandom_range(0, 9))
			0: run_insn(basic_insn(OPC_HALT));
			1: begin
				while (vm_sp > 0) run_insn(basic_insn(OPC_DROP));
				case ($urandom_range(0, 7))
					0: op = OPC_DROP;
					1: op = OPC_SWAP;
					2: op = OPC_ADD;
					3: op = OPC_SUB;
					4: op = OPC_XOR;
					5: op = OPC_STORE;
					6: op = OPC_PRINT;
					default: op = OPC_DUP;
				endcase
				it = basic_insn(op);
				it.tape_offset = tape_pick();
				run_insn(it);
			end
			2: begin
				while (vm_sp > 1) run_insn(basic_insn(OPC_DROP));
				if (vm_sp == 0) run_insn(basic_insn(OPC_PUSH));
				case ($urandom_range(0, 3))
					0: op = OPC_ADD;
					1: op = OPC_SUB;
					2: op = OPC_XOR;
					default: op = OPC_SWAP;
				endcase
				run_insn(basic_insn(op));
			end
			3: begin
				while (vm_sp < STACK_DEPTH) run_insn(basic_insn(OPC_PUSH));
				case ($urandom_range(0, 3))
					0: op = OPC_PUSH;
					1: op = OPC_DUP;
					2: op = OPC_LOAD;
					default: op = OPC_INPUT;
				endcase
				it = basic_insn(op);
				it.tape_offset = tape_pick();
				it.input_present = 1'b1;
				run_insn(it);
			end
			4: begin
				it = basic_insn($urandom_range(0, 1) ? OPC_LOAD : OPC_STORE);
				case ($urandom_range(0, 4))
					0: it.tape_offset = 16'h8000;
					1: it.tape_offset = 16'hffff;
					2: it.tape_offset = 16'(TAPE_DEPTH);
					3: it.tape_offset = 16'h7fff;
					default: it.tape_offset = 16'($urandom_range(TAPE_DEPTH, 65535));
				endcase
				run_insn(it);
			end
			5: begin
				it = basic_insn(opcode_t'($urandom_range(0, 15)));
				case ($urandom_range(0, 3))
					0: it.kind = 8'($urandom_range(OPS_VALID, 255));
					1: it.flag_bits = 8'($urandom_range(1, 255));
					2: it.spare_bits = $urandom | 32'h1 << $urandom_range(0, 31);
					default: it.kind = {4'h0, OPC_RSVD};
				endcase
				run_insn(it);
			end
			6: begin
				if (vm_sp == 0) run_insn(basic_insn(OPC_PUSH));
				wait_idle();
				write_limits(vm_prints, 10'd1023);
				run_insn(basic_insn(OPC_PRINT));
			end
			7: begin
				it = basic_insn(OPC_INPUT);
				it.input_present = 1'b0;
				run_insn(it);
			end
			8: run_insn(basic_insn(OPC_TRIGGER));
			default: begin
				wait_idle();
				if ($urandom_range(0, 1)) begin
					write_limits(lim_out, $urandom_range(0, 1) ? 10'd1 : vm_steps);
					run_insn(noise_insn());
				end else begin
					write_limits(lim_out, vm_steps + 10'd1);
					case ($urandom_range(0, 3))
						0: op = OPC_HALT;
						1: op = OPC_TRIGGER;
						2: op = OPC_NOP;
						default: op = OPC_PUSH;
					endcase
					run_insn(basic_insn(op));
				end
			end
		endcase
	endtask

	task automatic cmp_field(input string name, input logic [63:0] e, input logic [63:0] g);
		if (e !== g) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, e, g);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : out_idle_gen
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 10);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : status_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (status_q.size() == 0) begin
				$display("%0t: result item with nothing expected, expected none, got %h",
					$time, out_item);
				err_count++;
			end else begin
				want = status_q.pop_front();
				cmp_field("print_valid", want.print_valid, out_item.print_valid);
				cmp_field("print_value", want.print_value, out_item.print_value);
				cmp_field("halted", want.halted, out_item.halted);
				cmp_field("cause", want.cause, out_item.cause);
				cmp_field("stack_depth", want.stack_depth, out_item.stack_depth);
				cmp_field("done_res", want.done_res, out_item.done_res);
			end
		end
	end

	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int lo;
		in_valid <= 1'b0;
		in_item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_OUTPUT_LIMIT;
		cfg_data <= '0;
		arst_n <= 1'b0;
		vm_reset();

		dir_items.push_back(mk(OPC_NOP, 0, 0, 0, 0, 0));
		dir_typed.push_back(1); dir_res.push_back(res_of(0, 0, 0, CAUSE_RUN, 0, 0));
		dir_items.push_back(mk(OPC_LOAD, 0, 16'd255, 0, 0, 0));
		dir_typed.push_back(1); dir_res.push_back(res_of(0, 0, 0, CAUSE_RUN, 1, 0));
		dir_items.push_back(mk(OPC_PRINT, 0, 0, 0, 0, 0));
		dir_typed.push_back(1); dir_res.push_back(res_of(1, 0, 0, CAUSE_RUN, 0, 0));
		dir_items.push_back(mk(OPC_PUSH, '1, 0, 0, 0, 0));
		dir_typed.push_back(1); dir_res.push_back(res_of(0, 0, 0, CAUSE_RUN, 1, 0));
		dir_items.push_back(mk(OPC_PUSH, 0, 0, 0, 0, 0));
		dir_typed.push_back(1); dir_res.push_back(res_of(0, 0, 0, CAUSE_RUN, 2, 0));
		dir_items.push_back(mk(OPC_PUSH, 1, 0, 0, 0, 0));
		dir_items.push_back(mk(OPC_ADD, 0, 0, 0, 0, 0));
		dir_items.push_back(mk(OPC_ADD, 0, 0, 0, 0, 0));
		dir_items.push_back(mk(OPC_PUSH, 64'h8000_0000_0000_0000, 0, 0, 0, 0));
		dir_items.push_back(mk(OPC_SUB, 0, 0, 0, 0, 0));
		dir_items.push_back(mk(OPC_DUP, 0, 0, 0, 0, 0));
		dir_items.push_back(mk(OPC_XOR, 0, 0, 0, 0, 0));
		dir_items.push_back(mk(OPC_INPUT, 0, 0, '1, 1, 0));
		dir_items.push_back(mk(OPC_SWAP, 0, 0, 0, 0, 0));
		dir_items.push_back(mk(OPC_STORE, 0, 16'd255, 0, 0, 0));
		dir_items.push_back(mk(OPC_DUP, 0, 0, 0, 0, 0));
		dir_items.push_back(mk(OPC_STORE, 0, 16'd0, 0, 0, 0));
		dir_items.push_back(mk(OPC_LOAD, 0, 16'd0, 0, 0, 0));
		dir_items.push_back(mk(OPC_LOAD, 0, 16'd255, 0, 0, 0));
		dir_items.push_back(mk(OPC_HOME, 0, 0, 0, 0, 0));
		dir_items.push_back(mk(OPC_PRINT, 0, 0, 0, 0, 0));
		dir_items.push_back(mk(OPC_PRINT, 0, 0, 0, 0, 1));
		dir_items.push_back(mk(OPC_NOP, '1, 16'h7fff, '1, 1, 1));
		dir_items.push_back(mk(OPC_PUSH, 64'h5555_5555_5555_5555, 16'h8000, '1, 0, 0));
		dir_items.push_back(mk(OPC_PRINT, 0, 0, 0, 0, 0));
		while (dir_typed.size() < dir_items.size()) begin
			dir_typed.push_back(0);
			dir_res.push_back('0);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_items[i]) send_insn(dir_items[i], dir_typed[i], dir_res[i]);

		wait_idle();
		write_limits(8'd255, 10'd1023);
		run_clean(220, 15);

		wait_idle();
		lo = int'(vm_steps) + 230;
		if (lo > 1023) lo = 1023;
		write_limits(8'd0, 10'($urandom_range(1023, lo)));
		run_clean(220, 45);

		wait_idle();
		write_limits(8'($urandom_range(0, 255)), 10'd1023);
		run_clean(220, 5);

		wait_idle();
		write_limits(8'd255, 10'd1023);
		run_clean(220, 30);

		wait_idle();
		write_limits(8'd255, 10'd1023);
		finish_program();

		// The machine is halted now; everything after this must be ignored.
		quiet = 1'b1;
		repeat (320) begin
			run_insn(noise_insn());
			noise_n++;
		end
		set_valid(1'b0);

		while (status_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d instruction items: %0d executed steps, %0d prints, halt cause %0d.",
			n_items, vm_steps, vm_prints, vm_cause);
		$display("Several limit settings were run, then %0d items went to the halted machine.",
			noise_n);
		if (err_count == 0 && status_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
sv/svx_pkg.sv
sv/svx_decode.sv
sv/stack_vm_executor_unit.sv
verif/stack_vm_executor_unit_tb.sv
